>>> rtl/assert_macros.svh
// assertion macros shared by the vco band and charge pump selector rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define VCS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define VCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define VCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define VCS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/vcs_pkg.sv
// types, widths and constant thresholds for the vco band and charge pump selector
// no dependencies; imported by every module of the block
package vcs_pkg;

    localparam int unsigned LineTotalW  = 12;
    localparam int unsigned FrameLinesW = 11;
    localparam int unsigned VertRateW   = 8;
    localparam int unsigned BandW       = 2;
    localparam int unsigned CodeW       = 3;

    localparam int unsigned HfW   = VertRateW + FrameLinesW;
    localparam int unsigned PfW   = HfW + LineTotalW;
    localparam int unsigned ProdW = HfW + PfW;
    localparam int unsigned LhsW  = ProdW + 2;

    localparam int unsigned InTdataW  = 32;
    localparam int unsigned OutTdataW = 8;

    typedef enum logic [BandW-1:0] {
        BAND_LOW  = 2'd0,
        BAND_MID  = 2'd1,
        BAND_HIGH = 2'd2,
        BAND_TOP  = 2'd3
    } t_band;

    localparam logic [PfW-1:0] Band1Edge = 31'd42000000;
    localparam logic [PfW-1:0] Band2Edge = 31'd84000000;
    localparam logic [PfW-1:0] Band3Edge = 31'd140000000;

    // pump current I < T  <=>  hf*pf*P*98596 < T*600625*12195122*G
    localparam logic [127:0] PumpNumSq = 128'd98596;
    localparam logic [127:0] PumpBaseLow  = 128'd600625 * 128'd12195122 * 128'd150;
    localparam logic [127:0] PumpBaseHigh = 128'd600625 * 128'd12195122 * 128'd180;

    localparam int unsigned PumpEdges = 7;

    // smallest lhs that fails the threshold test, evaluated at elaboration
    function automatic logic [LhsW-1:0] pump_limit(input logic [127:0] edge_val,
                                                   input logic gain_hi);
        logic [127:0] rhs;
        logic [127:0] lim;
        rhs = edge_val * (gain_hi ? PumpBaseHigh : PumpBaseLow);
        lim = (rhs + PumpNumSq - 128'd1) / PumpNumSq;
        return lim[LhsW-1:0];
    endfunction

    localparam logic [LhsW-1:0] PumpLimLow [PumpEdges] = '{
        pump_limit(128'd75, 1'b0),  pump_limit(128'd125, 1'b0),
        pump_limit(128'd200, 1'b0), pump_limit(128'd300, 1'b0),
        pump_limit(128'd425, 1'b0), pump_limit(128'd625, 1'b0),
        pump_limit(128'd1125, 1'b0)
    };

    localparam logic [LhsW-1:0] PumpLimHigh [PumpEdges] = '{
        pump_limit(128'd75, 1'b1),  pump_limit(128'd125, 1'b1),
        pump_limit(128'd200, 1'b1), pump_limit(128'd300, 1'b1),
        pump_limit(128'd425, 1'b1), pump_limit(128'd625, 1'b1),
        pump_limit(128'd1125, 1'b1)
    };

    typedef struct packed {
        logic [LineTotalW-1:0]  line_total;
        logic [FrameLinesW-1:0] frame_lines;
        logic [VertRateW-1:0]   vertical_rate;
        logic                   interlaced;
    } t_timing_s;

    typedef struct packed {
        logic [HfW-1:0]        hf;
        logic [LineTotalW-1:0] line_total;
    } t_line_s;

    typedef struct packed {
        logic [HfW-1:0] hf;
        logic [PfW-1:0] pf;
    } t_pix_s;

    typedef struct packed {
        logic [ProdW-1:0] prod;
        t_band            band;
        logic             gain_hi;
    } t_band_s;

    typedef struct packed {
        t_band            band;
        logic [CodeW-1:0] code;
    } t_result_s;

endpackage

>>> rtl/pll_vco_charge_pump_select_unit.sv
// Picks the PLL VCO band and charge pump code for a video timing. Each request
// carries pixels per line, lines per frame, vertical rate and an interlace flag;
// one result with band and pump code comes back for each request, in order.
// Four register stages (line rate, pixel rate, band and product, pump compare)
// take a new request every cycle unless all four are full; each stage
// holds its item under back pressure, so a stalled output only blocks once
// all four stages are full. Zero anywhere in the timing gives band 0, code 0.
// depends on vcs_pkg, assert_macros.svh and the four stage modules
`include "assert_macros.svh"

module pll_vco_charge_pump_select_unit import vcs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // line_total[11:0], frame_lines[22:12], vertical_rate[30:23], zero[31]
    input  logic [InTdataW-1:0]  s_axis_tdata,
    // interlaced[0]
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // vco_band[1:0], pump_code[4:2], zero[7:5]
    output logic [OutTdataW-1:0] m_axis_tdata
);

    t_timing_s timing;
    logic      line_valid;
    logic      line_ready;
    t_line_s   line_data;
    logic      pix_valid;
    logic      pix_ready;
    t_pix_s    pix_data;
    logic      band_valid;
    logic      band_ready;
    t_band_s   band_data;
    t_result_s result;

    always_comb begin
        timing.line_total    = s_axis_tdata[LineTotalW-1:0];
        timing.frame_lines   = s_axis_tdata[LineTotalW +: FrameLinesW];
        timing.vertical_rate = s_axis_tdata[LineTotalW + FrameLinesW +: VertRateW];
        timing.interlaced    = s_axis_tuser;
    end

    vcs_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (timing),
        .o_valid (line_valid),
        .i_ready (line_ready),
        .o_data  (line_data)
    );

    vcs_pixel u_pixel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (line_valid),
        .o_ready (line_ready),
        .i_data  (line_data),
        .o_valid (pix_valid),
        .i_ready (pix_ready),
        .o_data  (pix_data)
    );

    vcs_band u_band (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pix_valid),
        .o_ready (pix_ready),
        .i_data  (pix_data),
        .o_valid (band_valid),
        .i_ready (band_ready),
        .o_data  (band_data)
    );

    vcs_pump u_pump (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (band_valid),
        .o_ready (band_ready),
        .i_data  (band_data),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (result)
    );

    assign m_axis_tdata = {{(OutTdataW - BandW - CodeW){1'b0}}, result.code, result.band};

    // input only backs up when the output holds a result
    `VCS_ASSERT(a_stall_needs_output, i_clk, i_rst_n, !s_axis_tready |-> m_axis_tvalid, "input stalled with empty output")
    // top band always lands above the lowest pump bucket
    `VCS_ASSERT(a_top_band_pump, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tdata[1:0] == BAND_TOP) |-> (m_axis_tdata[4:2] != 3'd0), "top band with lowest pump code")
    // pad bits never set
    `VCS_ASSERT_ALWAYS(a_pad_zero, i_clk, m_axis_tdata[OutTdataW-1:BandW+CodeW] == '0, "output pad bits set")

endmodule

>>> rtl/vcs_line.sv
// first stage: line rate from vertical rate and frame lines, halved when interlaced
// depends on vcs_pkg
module vcs_line import vcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_timing_s i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_line_s   o_data
);

    logic           r_valid;
    t_line_s        r_data;
    t_line_s        n_data;
    logic [HfW-1:0] hf_full;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        hf_full = HfW'(i_data.vertical_rate) * HfW'(i_data.frame_lines);
        n_data.hf         = i_data.interlaced ? (hf_full >> 1) : hf_full;
        n_data.line_total = i_data.line_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/vcs_pixel.sv
// second stage: pixel rate as line rate times pixels per line
// depends on vcs_pkg
module vcs_pixel import vcs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_line_s i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_pix_s  o_data
);

    logic   r_valid;
    t_pix_s r_data;
    t_pix_s n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data.hf = i_data.hf;
        n_data.pf = PfW'(i_data.hf) * PfW'(i_data.line_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/vcs_band.sv
// third stage: vco band and gain from the pixel rate, line rate times pixel rate
// depends on vcs_pkg
module vcs_band import vcs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_pix_s  i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_band_s o_data
);

    logic    r_valid;
    t_band_s r_data;
    t_band_s n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data.prod    = ProdW'(i_data.hf) * ProdW'(i_data.pf);
        n_data.gain_hi = (i_data.pf >= Band3Edge);
        priority if (i_data.pf < Band1Edge) begin
            n_data.band = BAND_LOW;
        end else if (i_data.pf < Band2Edge) begin
            n_data.band = BAND_MID;
        end else if (i_data.pf < Band3Edge) begin
            n_data.band = BAND_HIGH;
        end else begin
            n_data.band = BAND_TOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/vcs_pump.sv
// last stage: post divider scaling and pump code from seven threshold compares
// depends on vcs_pkg; its register is the output register of the block
module vcs_pump import vcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_band_s   i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_result_s o_data
);

    logic                 r_valid;
    t_result_s            r_data;
    t_result_s            n_data;
    logic [LhsW-1:0]      lhs;
    logic [PumpEdges-1:0] below;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        unique case (i_data.band)
            BAND_LOW:  lhs = {i_data.prod, 2'b00};
            BAND_MID:  lhs = {1'b0, i_data.prod, 1'b0};
            default:   lhs = {2'b00, i_data.prod};
        endcase
        for (int i = 0; i < PumpEdges; i++) begin
            below[i] = lhs < (i_data.gain_hi ? PumpLimHigh[i] : PumpLimLow[i]);
        end
        n_data.band = i_data.band;
        n_data.code = CodeW'(PumpEdges);
        for (int i = PumpEdges - 1; i >= 0; i--) begin
            if (below[i]) begin
                n_data.code = CodeW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> tb/pll_vco_charge_pump_select_unit_tb.sv
// testbench for the pll vco band and charge pump selector: directed timing table, then
// random video timings under random sender bursts and receiver stalls, checked in order
// depends on vcs_pkg and pll_vco_charge_pump_select_unit
module pll_vco_charge_pump_select_unit_tb;
    import vcs_pkg::*;

    localparam longint unsigned Band1Hz = 64'd42000000;
    localparam longint unsigned Band2Hz = 64'd84000000;
    localparam longint unsigned Band3Hz = 64'd140000000;
    localparam longint unsigned GainLow = 64'd150;
    localparam longint unsigned GainHigh = 64'd180;
    localparam int unsigned NumPumpSteps = 7;
    localparam longint unsigned PumpStep [NumPumpSteps] = '{
        64'd75, 64'd125, 64'd200, 64'd300, 64'd425, 64'd625, 64'd1125
    };
    localparam int unsigned RandomItems = 1750;
    localparam int unsigned StallLimit = 5000;
    localparam int unsigned TailCycles = 12;

    typedef struct packed {
        t_band            band;
        logic [CodeW-1:0] code;
    } t_pump_sel;

    typedef struct {
        t_timing_s timing;
        logic      typed;
        t_pump_sel sel;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // line_total[11:0], frame_lines[22:12], vertical_rate[30:23], zero[31]
    logic [InTdataW-1:0]  s_axis_tdata = '0;
    // interlaced[0]
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // vco_band[1:0], pump_code[4:2], zero[7:5]
    logic [OutTdataW-1:0] m_axis_tdata;

    t_pump_sel   pending_sels [$];
    t_dir_row    timing_table [$];
    logic        typed_now = 1'b0;
    t_pump_sel   typed_sel = '0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    logic        ready_on = 1'b0;
    int unsigned ready_left = 0;

    pll_vco_charge_pump_select_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_pump_sel predict_pump_sel(input t_timing_s t);
        logic [HfW-1:0]   line_rate;
        logic [PfW-1:0]   pix_rate;
        longint unsigned  post_div;
        longint unsigned  gain;
        logic [127:0]     lhs;
        logic [127:0]     base;
        t_pump_sel        sel;
        line_rate = HfW'(t.vertical_rate) * HfW'(t.frame_lines);
        if (t.interlaced) begin
            line_rate = line_rate >> 1;
        end
        pix_rate = PfW'(line_rate) * PfW'(t.line_total);
        gain = (pix_rate < Band3Hz) ? GainLow : GainHigh;
        if (pix_rate < Band1Hz) begin
            sel.band = BAND_LOW;
            post_div = 4;
        end else if (pix_rate < Band2Hz) begin
            sel.band = BAND_MID;
            post_div = 2;
        end else if (pix_rate < Band3Hz) begin
            sel.band = BAND_HIGH;
            post_div = 1;
        end else begin
            sel.band = BAND_TOP;
            post_div = 1;
        end
        // exact form of (hf*314/775)^2/12195122*ht*P/G < step
        lhs = 128'(line_rate) * 128'(pix_rate) * 128'(post_div) * 128'd98596;
        base = 128'd600625 * 128'd12195122 * 128'(gain);
        sel.code = CodeW'(NumPumpSteps);
        for (int k = NumPumpSteps - 1; k >= 0; k--) begin
            if (lhs < 128'(PumpStep[k]) * base) begin
                sel.code = CodeW'(k);
            end
        end
        return sel;
    endfunction

    function automatic t_timing_s random_timing();
        t_timing_s t;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        t.interlaced = 1'($urandom_range(0, 1));
        if (pick < 5) begin
            t.line_total = 12'($urandom_range(200, 2700));
            t.frame_lines = 11'($urandom_range(240, 1250));
            t.vertical_rate = 8'($urandom_range(23, 125));
        end else if (pick < 7) begin
            t.line_total = 12'($urandom_range(1, 900));
            t.frame_lines = 11'($urandom_range(1, 320));
            t.vertical_rate = 8'($urandom_range(1, 60));
        end else begin
            t.line_total = 12'($urandom);
            t.frame_lines = 11'($urandom);
            t.vertical_rate = 8'($urandom);
            if (pick == 9) begin
                case ($urandom_range(0, 2))
                    0: t.line_total = '0;
                    1: t.frame_lines = '0;
                    default: t.vertical_rate = '0;
                endcase
            end
        end
        return t;
    endfunction

    task automatic add_row(input int ht, input int vt, input int vf, input bit il,
                           input bit typed, input t_band band, input int code);
        t_dir_row row;
        row.timing = '{line_total: 12'(ht), frame_lines: 11'(vt), vertical_rate: 8'(vf),
                       interlaced: il};
        row.typed = typed;
        row.sel = '{band: band, code: CodeW'(code)};
        timing_table.push_back(row);
    endtask

    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 5))
                0: gap = 0;
                1: gap = $urandom_range(9, 20);
                default: gap = $urandom_range(1, 5);
            endcase
            if (gap != 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
    endtask

    task automatic send_timing(input t_timing_s t, input logic typed, input t_pump_sel sel);
        pace_sender();
        @(negedge i_clk);
        s_axis_tdata <= InTdataW'({t.vertical_rate, t.frame_lines, t.line_total});
        s_axis_tuser <= t.interlaced;
        s_axis_tvalid <= 1'b1;
        typed_now <= typed;
        typed_sel <= sel;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_sels.size() != 0) @(negedge i_clk);
    endtask

    // receiver: ready runs with short or long stalls between them
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            if (!ready_on || $urandom_range(0, 3) == 0) begin
                ready_on = 1'b1;
                ready_left = $urandom_range(1, 40);
            end else begin
                ready_on = 1'b0;
                ready_left = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30)
                                                         : $urandom_range(1, 3);
            end
        end
        ready_left--;
        m_axis_tready <= ready_on;
    end

    always @(posedge i_clk) begin
        t_timing_s t;
        t_pump_sel want;
        logic      moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1'b1;
                t = t_timing_s'({s_axis_tdata[LineTotalW+FrameLinesW+VertRateW-1:0],
                                 s_axis_tuser});
                t.line_total = s_axis_tdata[LineTotalW-1:0];
                t.frame_lines = s_axis_tdata[LineTotalW+:FrameLinesW];
                t.vertical_rate = s_axis_tdata[LineTotalW+FrameLinesW+:VertRateW];
                t.interlaced = s_axis_tuser;
                pending_sels.push_back(typed_now ? typed_sel : predict_pump_sel(t));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                if (pending_sels.size() == 0) begin
                    $error("unexpected result: tdata %0h", m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = pending_sels.pop_front();
                    if (m_axis_tdata[BandW-1:0] !== want.band) begin
                        $error("vco_band: expected %0d, actual %0d",
                               want.band, m_axis_tdata[BandW-1:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[BandW+:CodeW] !== want.code) begin
                        $error("pump_code: expected %0d, actual %0d",
                               want.code, m_axis_tdata[BandW+:CodeW]);
                        mismatch_count++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= StallLimit) begin
                $display("pll_vco_charge_pump_select_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        t_timing_s t;
        // zero timing and truncation to zero, full-scale, band edges, common formats
        add_row(0, 0, 0, 0, 1, BAND_LOW, 0);
        add_row(0, 2047, 255, 1, 1, BAND_LOW, 0);
        add_row(4095, 0, 255, 0, 1, BAND_LOW, 0);
        add_row(4095, 2047, 0, 1, 1, BAND_LOW, 0);
        add_row(4095, 1, 1, 1, 1, BAND_LOW, 0);
        add_row(4095, 2047, 255, 0, 1, BAND_TOP, 7);
        add_row(4095, 2047, 255, 1, 1, BAND_TOP, 7);
        add_row(1, 1, 1, 0, 0, BAND_LOW, 0);
        add_row(1999, 350, 60, 0, 0, BAND_LOW, 0);
        add_row(2000, 350, 60, 0, 0, BAND_LOW, 0);
        add_row(1999, 700, 60, 0, 0, BAND_LOW, 0);
        add_row(2000, 700, 60, 0, 0, BAND_LOW, 0);
        add_row(1999, 1000, 70, 0, 0, BAND_LOW, 0);
        add_row(2000, 1000, 70, 0, 0, BAND_LOW, 0);
        add_row(800, 525, 60, 0, 0, BAND_LOW, 0);
        add_row(858, 525, 60, 1, 0, BAND_LOW, 0);
        add_row(858, 525, 61, 1, 0, BAND_LOW, 0);
        add_row(1650, 750, 60, 0, 0, BAND_LOW, 0);
        add_row(2200, 1125, 60, 0, 0, BAND_LOW, 0);
        add_row(2200, 1125, 60, 1, 0, BAND_LOW, 0);
        add_row(2160, 1250, 120, 0, 0, BAND_LOW, 0);
        add_row(100, 100, 10, 0, 0, BAND_LOW, 0);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (timing_table[i]) begin
            send_timing(timing_table[i].timing, timing_table[i].typed, timing_table[i].sel);
        end
        wait_drained();

        for (int n = 0; n < RandomItems; n++) begin
            t = random_timing();
            send_timing(t, 1'b0, '0);
            if (n % 500 == 499) begin
                wait_drained();
            end
        end
        wait_drained();
        repeat (TailCycles) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("pll_vco_charge_pump_select_unit: match");
        end else begin
            $display("pll_vco_charge_pump_select_unit: mismatch");
        end
        $finish;
    end

endmodule
